// ===== rtl/sdtl_pkg.sv =====
// shared types and constants for the sorted dispatch table lookup
`default_nettype none
package sdtl_pkg;

  // request operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // configuration register indexes (word address bit 2)
  localparam logic REG_ENTRY_COUNT = 1'b0;

  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;

  // request payload
  typedef struct packed {
    logic        operation;
    logic [9:0]  entry_index;
    logic [31:0] entry_address;
    logic        entry_thumb;
    logic        entry_resume;
    logic [31:0] entry_handler;
    logic [31:0] lookup_pc;
    logic        lookup_thumb;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic        found;
    logic [31:0] handler;
    logic        resume_flag;
  } out_rsp_t;

  // one stored table row
  typedef struct packed {
    logic [31:0] address;
    logic        thumb;
    logic        resume;
    logic [31:0] handler;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== rtl/sdtl_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
`default_nettype none
module sdtl_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_dispatch_table_lookup_top.sv =====
// top level of the sorted dispatch table lookup: table ram, search sequencer, apb register
//
// Usage
//   Requests arrive on in_req and are taken when start is high and busy is low.
//   A write request stores one row at entry_index (no result, busy stays
//   low); indexes at or above TABLE_DEPTH are dropped. A lookup request clears bit 0
//   of lookup_pc, runs a lower-bound binary search over the first entry_count rows
//   (at most TABLE_DEPTH), then scans the rows of that exact address for a thumb match.
//   The result appears on out_rsp for exactly one cycle with out_valid high; the
//   receiver cannot stall it, and it does not block the next request.
//   Timing: one table ram read per cycle. A lookup runs the search steps, then one
//   read per scanned row, then registers the result; a zero count answers in the
//   cycle after the request is taken, without a table read. Busy is high while the
//   search or scan runs.
//   The entry_count register sits at byte address 0 of the apb port, readable and
//   writable. The user must write it only while no lookup is running; the block does
//   not enforce this. Reset clears the sequencer state, the result strobe and
//   entry_count; table rows are undefined until written.
`default_nettype none
module sorted_dispatch_table_lookup_top #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sdtl_pkg::in_req_t in_req,
  output logic                   out_valid,
  output sdtl_pkg::out_rsp_t     out_rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int CW = sdtl_pkg::COUNT_W;
  localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCAN
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cfg_count_r;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [31:0]        pc_r, pc_nxt;
  logic               want_r, want_nxt;
  logic               out_valid_r, out_valid_nxt;
  sdtl_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;

  logic               accept;
  logic [CW-1:0]      count_sat;
  logic               wr_en;
  logic [31:0]        wr_idx_ext;
  logic [31:0]        rd_ptr_ext;
  logic [CW-1:0]      rd_ptr;
  logic [AW-1:0]      rd_addr;
  logic [sdtl_pkg::ENTRY_W-1:0] rd_data;
  sdtl_pkg::entry_t   rd_entry;
  sdtl_pkg::entry_t   wr_entry;

  logic               below;
  logic [CW-1:0]      lo_s, hi_s;
  logic [CW:0]        sum_s;
  logic [CW-1:0]      ptr_inc;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // apb register port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == sdtl_pkg::REG_ENTRY_COUNT) begin
      prdata = {{(32-CW){1'b0}}, cfg_count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sdtl_pkg::REG_ENTRY_COUNT) begin
      cfg_count_r <= pwdata[CW-1:0];
    end
  end

  // usable row count, limited to the table depth
  assign count_sat = ({{(32-CW){1'b0}}, cfg_count_r} > DEPTH_U) ? DEPTH_U[CW-1:0]
                                                               : cfg_count_r;

  // table write path
  assign wr_idx_ext = {{(32-sdtl_pkg::INDEX_W){1'b0}}, in_req.entry_index};
  assign wr_en = accept && (in_req.operation == sdtl_pkg::OP_WRITE) &&
                 (wr_idx_ext < DEPTH_U);
  assign wr_entry.address = in_req.entry_address;
  assign wr_entry.thumb   = in_req.entry_thumb;
  assign wr_entry.resume  = in_req.entry_resume;
  assign wr_entry.handler = in_req.entry_handler;

  assign rd_ptr_ext = {{(32-CW){1'b0}}, rd_ptr};
  assign rd_addr    = rd_ptr_ext[AW-1:0];
  assign rd_entry   = rd_data;

  sdtl_ram #(
    .WIDTH (sdtl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_ext[AW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // one bisection step on the row just read
  assign below   = (rd_entry.address < pc_r);
  assign lo_s    = below ? ptr_inc : lo_r;
  assign hi_s    = below ? hi_r : ptr_r;
  assign sum_s   = {1'b0, lo_s} + {1'b0, hi_s};
  assign ptr_inc = ptr_r + CW'(1);

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    pc_nxt        = pc_r;
    want_nxt      = want_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    rd_ptr        = ptr_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_req.operation == sdtl_pkg::OP_LOOKUP) begin
          pc_nxt   = {in_req.lookup_pc[31:1], 1'b0};
          want_nxt = in_req.lookup_thumb;
          cnt_nxt  = count_sat;
          lo_nxt   = '0;
          hi_nxt   = count_sat;
          ptr_nxt  = count_sat >> 1;
          rd_ptr   = count_sat >> 1;
          if (count_sat == '0) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s < hi_s) begin
          ptr_nxt = sum_s[CW:1];
          rd_ptr  = sum_s[CW:1];
        end else if (lo_s < cnt_r) begin
          ptr_nxt   = lo_s;
          rd_ptr    = lo_s;
          state_nxt = ST_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (rd_entry.address != pc_r) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          state_nxt     = ST_IDLE;
        end else if (rd_entry.thumb == want_r) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          if (rd_entry.handler != '0) begin
            out_rsp_nxt.found       = 1'b1;
            out_rsp_nxt.handler     = rd_entry.handler;
            out_rsp_nxt.resume_flag = rd_entry.resume;
          end
          state_nxt = ST_IDLE;
        end else if (ptr_inc < cnt_r) begin
          ptr_nxt = ptr_inc;
          rd_ptr  = ptr_inc;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r     <= ptr_nxt;
    cnt_r     <= cnt_nxt;
    pc_r      <= pc_nxt;
    want_r    <= want_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the sorted dispatch table lookup block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  localparam int LONG_WAIT_LIMIT = 4_000_000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  sdtl_pkg::in_req_t  in_req;
  logic               out_valid;
  sdtl_pkg::out_rsp_t out_rsp;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // shadow copy of the table and the count register
  sdtl_pkg::entry_t   table_rows [TABLE_DEPTH];
  logic [10:0]        entry_count_shadow;
  sdtl_pkg::out_rsp_t lookup_answers_q[$];
  int                 error_count;
  int                 writes_sent;
  int                 lookups_sent;
  int                 hits_seen;
  int                 count_settings;
  bit                 no_idle;

  sorted_dispatch_table_lookup_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #LONG_WAIT_LIMIT;
    $display("tb_top failed");
    $finish;
  end

  // lower-bound search then scan of the equal-address run
  function automatic sdtl_pkg::out_rsp_t predict_lookup(logic [31:0] pc_raw,
                                                        logic want_thumb);
    sdtl_pkg::out_rsp_t rsp;
    int                 n;
    int                 lo;
    int                 hi;
    int                 mid;
    logic [31:0]        pc;
    rsp = '0;
    n = (int'(entry_count_shadow) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_shadow);
    pc = pc_raw & ~32'd1;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (table_rows[mid].address < pc) lo = mid + 1;
      else hi = mid;
    end
    for (int i = lo; i < n && table_rows[i].address == pc; i++) begin
      if (table_rows[i].thumb == want_thumb) begin
        if (table_rows[i].handler != 32'd0) begin
          rsp.found       = 1'b1;
          rsp.handler     = table_rows[i].handler;
          rsp.resume_flag = table_rows[i].resume;
        end
        break;
      end
    end
    return rsp;
  endfunction

  // request with every field random; callers overwrite what matters
  function automatic sdtl_pkg::in_req_t random_req();
    sdtl_pkg::in_req_t r;
    r.operation     = 1'($urandom);
    r.entry_index   = 10'($urandom);
    r.entry_address = $urandom;
    r.entry_thumb   = 1'($urandom);
    r.entry_resume  = 1'($urandom);
    r.entry_handler = $urandom;
    r.lookup_pc     = $urandom;
    r.lookup_thumb  = 1'($urandom);
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drive one request and update the shadow state once it is taken
  task automatic send_req(input sdtl_pkg::in_req_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.operation == sdtl_pkg::OP_WRITE) begin
      table_rows[r.entry_index] = '{r.entry_address, r.entry_thumb, r.entry_resume,
                                    r.entry_handler};
      writes_sent++;
    end else begin
      lookup_answers_q.push_back(predict_lookup(r.lookup_pc, r.lookup_thumb));
      lookups_sent++;
    end
  endtask

  task automatic write_row(input int idx, input logic [31:0] addr, input logic thumb,
                           input logic resume, input logic [31:0] handler);
    sdtl_pkg::in_req_t r;
    r = random_req();
    r.operation     = sdtl_pkg::OP_WRITE;
    r.entry_index   = 10'(idx);
    r.entry_address = addr;
    r.entry_thumb   = thumb;
    r.entry_resume  = resume;
    r.entry_handler = handler;
    send_req(r);
  endtask

  task automatic lookup(input logic [31:0] pc, input logic thumb);
    sdtl_pkg::in_req_t r;
    r = random_req();
    r.operation    = sdtl_pkg::OP_LOOKUP;
    r.lookup_pc    = pc;
    r.lookup_thumb = thumb;
    send_req(r);
  endtask

  // drop start and wait until every lookup has answered
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (lookup_answers_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write then read back of the count register
  task automatic set_count(input logic [10:0] value);
    logic [2:0] addr;
    addr = {sdtl_pkg::REG_ENTRY_COUNT, 2'b00};
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {21'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    entry_count_shadow = value;
    count_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[sdtl_pkg::COUNT_W-1:0] !== value) begin
      $error("entry_count readback: expected %0d actual %0d", value,
             prdata[sdtl_pkg::COUNT_W-1:0]);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (lookup_answers_q.size() == 0) begin
        $error("result with no lookup outstanding: found %0b handler %h",
               out_rsp.found, out_rsp.handler);
        error_count++;
      end else begin
        sdtl_pkg::out_rsp_t want;
        want = lookup_answers_q.pop_front();
        if (want.found) hits_seen++;
        if (out_rsp.found !== want.found) begin
          $error("found: expected %0b actual %0b", want.found, out_rsp.found);
          error_count++;
        end
        if (out_rsp.handler !== want.handler) begin
          $error("handler: expected %h actual %h", want.handler, out_rsp.handler);
          error_count++;
        end
        if (out_rsp.resume_flag !== want.resume_flag) begin
          $error("resume_flag: expected %0b actual %0b", want.resume_flag,
                 out_rsp.resume_flag);
          error_count++;
        end
      end
    end
  end

  // count of zero after reset: no table row is touched
  task automatic test_zero_count();
    lookup(32'h0000_0000, 1'b0);
    lookup(32'hFFFF_FFFF, 1'b1);
    lookup($urandom, 1'($urandom));
  endtask

  // small hand-built table covering the corner cases
  task automatic test_directed_table();
    write_row(0, 32'h0000_0000, 1'b0, 1'b1, 32'h1111_0000);
    write_row(1, 32'h0000_0100, 1'b0, 1'b1, 32'h0000_0000);
    write_row(2, 32'h0000_0100, 1'b1, 1'b1, 32'h2222_2222);
    write_row(3, 32'h0000_0100, 1'b0, 1'b0, 32'h3333_3333);
    write_row(4, 32'h0000_0201, 1'b0, 1'b1, 32'h4444_4444);
    write_row(5, 32'h0000_0300, 1'b1, 1'b0, 32'h5555_5555);
    write_row(6, 32'h0000_0300, 1'b1, 1'b1, 32'h6666_6666);
    write_row(7, 32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF);
    write_row(8, 32'hFFFF_FFFE, 1'b1, 1'b0, 32'h8888_8888);
    write_row(9, 32'hFFFF_FFFE, 1'b0, 1'b1, 32'h9999_9999);
    set_count(11'd10);
    lookup(32'h0000_0000, 1'b0);   // first row
    lookup(32'h0000_0001, 1'b0);   // pc bit 0 ignored
    lookup(32'h0000_0100, 1'b0);   // first flag match has no handler
    lookup(32'h0000_0101, 1'b1);   // match further down the run
    lookup(32'h0000_0200, 1'b0);   // lands on odd key, no match
    lookup(32'h0000_0300, 1'b0);   // run without the wanted flag
    lookup(32'h0000_0300, 1'b1);
    lookup(32'h8000_0001, 1'b0);
    lookup(32'h7FFF_FFFE, 1'b1);   // falls between keys
    lookup(32'hFFFF_FFFF, 1'b0);   // last row, scan past a flag mismatch
    set_count(11'd5);
    lookup(32'h0000_0300, 1'b1);   // key past the valid count
    set_count(11'd0);
    lookup(32'h0000_0101, 1'b1);
  endtask

  // full depth and saturating counts; rows are written only along the two outer
  // search paths, and lookups stay on those paths
  task automatic test_saturated_count();
    bit          on_path [TABLE_DEPTH];
    logic [10:0] counts [2];
    logic [31:0] base;
    logic [31:0] last_key;
    logic [31:0] pc;
    int          lo;
    int          hi;
    int          mid;
    int          sel;
    counts = '{11'd1024, 11'd2047};
    base = ($urandom & 32'h0FFF_FFF0) | 32'h0000_0100;
    last_key = base + 32'(16 * (TABLE_DEPTH - 1));
    // mark the rows read by a search below every key and above every key
    for (int side = 0; side < 2; side++) begin
      lo = 0;
      hi = TABLE_DEPTH;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        on_path[mid] = 1'b1;
        if (side == 1) lo = mid + 1;
        else hi = mid;
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (on_path[i]) begin
        write_row(i, base + 32'(16 * i), 1'($urandom), 1'($urandom),
                  ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom);
      end
    end
    foreach (counts[c]) begin
      set_count(counts[c]);
      repeat (8) begin
        sel = $urandom_range(0, 3);
        case (sel)
          0: pc = base - 32'd2 - 32'(2 * $urandom_range(0, 100));   // below every key
          1: pc = base ^ 32'($urandom & 1);                         // first row
          2: pc = last_key ^ 32'($urandom & 1);                     // last row
          default: pc = last_key + 32'(2 * $urandom_range(1, 100)); // above every key
        endcase
        lookup(pc, 1'($urandom));
      end
    end
  endtask

  // phases: build a mostly sorted table, then mixed lookups and rewrites
  task automatic test_random_phases();
    int          rand_items;
    int          n;
    int          k;
    int          idx;
    logic [31:0] key;
    logic [31:0] pc;
    rand_items = 0;
    while (rand_items < 580) begin
      k = $urandom_range(0, 19);
      if (k == 0) n = 0;
      else if (k == 1) n = $urandom_range(100, 300);
      else n = $urandom_range(1, 48);
      no_idle = ($urandom_range(0, 3) == 0);
      key = ($urandom_range(0, 7) == 0) ? (32'hFFFF_FFFE - 32'(8 * n)) : $urandom;
      key &= ~32'd1;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) != 0) key += 32'(2 * $urandom_range(1, 3));
        write_row(i, key | (($urandom_range(0, 15) == 0) ? 32'd1 : 32'd0), 1'($urandom),
                  1'($urandom), ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
        rand_items++;
      end
      set_count(11'(n));
      repeat ($urandom_range(20, 40)) begin
        k = $urandom_range(0, 99);
        if (k < 25 && n > 0) begin
          // rewrite a row, mostly keeping its key
          idx = $urandom_range(0, n - 1);
          key = table_rows[idx].address;
          if ($urandom_range(0, 3) == 0) begin
            idx = $urandom_range(0, TABLE_DEPTH - 1);
            key = $urandom;
          end
          write_row(idx, key, 1'($urandom), 1'($urandom),
                    ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
        end else begin
          k = $urandom_range(0, 99);
          if (n > 0 && k < 70)
            pc = table_rows[$urandom_range(0, n - 1)].address ^ 32'($urandom & 1);
          else if (n > 0 && k < 85)
            pc = table_rows[$urandom_range(0, n - 1)].address +
                 ($urandom_range(0, 1) ? 32'd2 : -32'd2);
          else
            pc = $urandom;
          lookup(pc, 1'($urandom));
        end
        rand_items++;
      end
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    entry_count_shadow = '0;
    error_count    = 0;
    writes_sent    = 0;
    lookups_sent   = 0;
    hits_seen      = 0;
    count_settings = 0;
    no_idle        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_count();
    test_directed_table();
    test_saturated_count();
    test_random_phases();

    wait_idle();
    repeat (30) @(posedge clk);
    $display("covered %0d row writes and %0d lookups (%0d hits) over %0d count settings",
             writes_sent, lookups_sent, hits_seen, count_settings);
    $display("%0d mismatches", error_count);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sdtl_pkg.sv
rtl/sdtl_ram.sv
rtl/sorted_dispatch_table_lookup_top.sv
verif/tb_top.sv
